// File: design/iaenc_pkg.sv
// ----------------------------------------------------------------------------
// iaenc_pkg
// Shared types, constants and lookup tables of the IMA ADPCM block encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package iaenc_pkg;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = 1;
  localparam int unsigned QCNT_W   = 2;
  localparam int unsigned HDR_LEN  = 4;

  localparam logic [6:0] IDX_MAX   = 7'd88;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;

  typedef struct packed {
    logic signed [15:0] sample_even;
    logic signed [15:0] sample_odd;
    logic               first_of_block;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic [3:0]         code;
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } step_res_t;

  typedef enum logic [2:0] {
    ST_LO  = 3'b001,
    ST_HI  = 3'b010,
    ST_HDR = 3'b100
  } back_state_e;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // magnitude bits of the code pick the index change; sign bit does not matter
  function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: design/iaenc_front.sv
// ----------------------------------------------------------------------------
// iaenc_front
// Input side: takes sample pairs and holds them in a short queue for the
// coding back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iaenc_front
  import iaenc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pair_t              in_pair_i,
  output logic                    q_valid_o,
  output pair_t                   q_pair_o,
  input  wire logic               q_pop_i
);

  pair_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push, pop;

  assign in_stall_o = (cnt_q == QCNT_W'(QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_pair_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_pair_i;
    end
  end

endmodule

`default_nettype wire

// File: design/iaenc_step.sv
// ----------------------------------------------------------------------------
// iaenc_step
// One IMA ADPCM coding step: quantize a sample against the predictor and
// produce the code, the saturated predictor and the clamped step index.
// ----------------------------------------------------------------------------
`default_nettype none

module iaenc_step
  import iaenc_pkg::*;
(
  input  wire logic signed [15:0] smp_i,
  input  wire logic signed [15:0] pred_i,
  input  wire logic [6:0]         idx_i,
  output step_res_t               res_o
);

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic signed [16:0] diff;
  logic               neg;
  logic [16:0]        mag, m1, m2;
  logic               b2, b1, b0;
  logic [16:0]        dq;
  logic signed [17:0] np;
  logic signed [7:0]  ni;

  always_comb begin
    idx_c = (idx_i > IDX_MAX) ? IDX_MAX : idx_i;
    step  = step_size(idx_c);
    diff  = {smp_i[15], smp_i} - {pred_i[15], pred_i};
    neg   = diff[16];
    mag   = neg ? 17'(-diff) : 17'(diff);

    b2 = (mag >= {2'b00, step});
    m1 = b2 ? mag - {2'b00, step} : mag;
    b1 = (m1 >= {3'b000, step[14:1]});
    m2 = b1 ? m1 - {3'b000, step[14:1]} : m1;
    b0 = (m2 >= {4'b0000, step[14:2]});

    dq = {5'd0, step[14:3]}
       + (b2 ? {2'b00, step} : 17'd0)
       + (b1 ? {3'b000, step[14:1]} : 17'd0)
       + (b0 ? {4'b0000, step[14:2]} : 17'd0);

    np = neg ? {{2{pred_i[15]}}, pred_i} - $signed({1'b0, dq})
             : {{2{pred_i[15]}}, pred_i} + $signed({1'b0, dq});

    ni = $signed({1'b0, idx_c}) + 8'(idx_adjust({b2, b1, b0}));

    res_o.code = {neg, b2, b1, b0};
    if (np > PRED_MAX) begin
      res_o.pred = 16'sh7FFF;
    end else if (np < PRED_MIN) begin
      res_o.pred = 16'sh8000;
    end else begin
      res_o.pred = np[15:0];
    end
    if (ni < 0) begin
      res_o.idx = '0;
    end else if (ni > $signed({1'b0, IDX_MAX})) begin
      res_o.idx = IDX_MAX;
    end else begin
      res_o.idx = ni[6:0];
    end
  end

endmodule

`default_nettype wire

// File: design/iaenc_back.sv
// ----------------------------------------------------------------------------
// iaenc_back
// Coding back end: emits the block header, codes both samples of a pair one
// step per cycle unless stalled and packs the codes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iaenc_back
  import iaenc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire pair_t q_pair_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_block_o
);

  back_state_e        state_q, state_d;
  logic [1:0]         hdr_cnt_q, hdr_cnt_d;
  logic               hdr_done_q, hdr_done_d;
  logic signed [15:0] pred_q, pred_d;
  logic [6:0]         idx_q, idx_d;
  logic [3:0]         lo_code_q, lo_code_d;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               last_q, last_d;
  logic               eob_q, eob_d;

  logic               out_free, emit;
  logic signed [15:0] st_smp, st_pred;
  step_res_t          st_res;
  logic [15:0]        hdr_pred;

  assign out_free = !out_valid_q || !out_stall_i;
  assign hdr_pred = q_pair_i.sample_even;

  always_comb begin
    st_smp  = q_pair_i.sample_even;
    st_pred = pred_q;
    if (state_q == ST_HI) begin
      st_smp = q_pair_i.sample_odd;
    end else if (q_pair_i.first_of_block) begin
      st_pred = q_pair_i.sample_even;
    end
  end

  iaenc_step u_step (
    .smp_i  (st_smp),
    .pred_i (st_pred),
    .idx_i  (idx_q),
    .res_o  (st_res)
  );

  always_comb begin
    state_d    = state_q;
    hdr_cnt_d  = hdr_cnt_q;
    hdr_done_d = hdr_done_q;
    pred_d     = pred_q;
    idx_d      = idx_q;
    lo_code_d  = lo_code_q;
    emit       = 1'b0;
    out_byte_d = out_byte_q;
    last_d     = last_q;
    eob_d      = eob_q;
    q_pop_o    = 1'b0;

    case (state_q)
      ST_LO: begin
        if (q_valid_i) begin
          if (q_pair_i.first_of_block && !hdr_done_q) begin
            hdr_cnt_d = '0;
            state_d   = ST_HDR;
          end else begin
            pred_d    = st_res.pred;
            idx_d     = st_res.idx;
            lo_code_d = st_res.code;
            state_d   = ST_HI;
          end
        end
      end
      ST_HDR: begin
        if (out_free) begin
          emit   = 1'b1;
          last_d = 1'b0;
          eob_d  = 1'b0;
          case (hdr_cnt_q)
            2'd0:    out_byte_d = hdr_pred[7:0];
            2'd1:    out_byte_d = hdr_pred[15:8];
            2'd2:    out_byte_d = {1'b0, idx_q};
            default: out_byte_d = 8'h00;
          endcase
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == 2'(HDR_LEN - 1)) begin
            hdr_done_d = 1'b1;
            state_d    = ST_LO;
          end
        end
      end
      ST_HI: begin
        if (out_free) begin
          emit       = 1'b1;
          out_byte_d = {st_res.code, lo_code_q};
          last_d     = 1'b1;
          eob_d      = q_pair_i.last_pair;
          pred_d     = st_res.pred;
          idx_d      = st_res.idx;
          hdr_done_d = 1'b0;
          q_pop_o    = 1'b1;
          state_d    = ST_LO;
        end
      end
      default: begin
        state_d = ST_LO;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LO;
      hdr_cnt_q   <= '0;
      hdr_done_q  <= 1'b0;
      pred_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_cnt_q   <= hdr_cnt_d;
      hdr_done_q  <= hdr_done_d;
      pred_q      <= pred_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_code_q  <= lo_code_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    eob_q      <= eob_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = last_q;
  assign end_of_block_o = eob_q;

endmodule

`default_nettype wire

// File: design/ima_adpcm_block_encoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_block_encoder
// IMA ADPCM encoder: sample pairs in, packed 4-bit code bytes out, with a
// four-byte header at each block start.
// ----------------------------------------------------------------------------
// Ordering: a pair's packed byte is registered when its odd sample is coded,
//   after a setup state and the 4 header bytes for a block-start pair.
// Sharing: both samples go through the one shared coding step, used once per
//   sample; the back end codes one pair at a time and pops it once packed.
// Reset: predictor and step index clear to 0, queue and output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_encoder
  import iaenc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] sample_even_i,
  input  wire logic [15:0] sample_odd_i,
  input  wire logic        first_of_block_i,
  input  wire logic        last_pair_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             end_of_block_o
);

  pair_t in_pair, q_pair;
  logic  q_valid, q_pop;

  assign in_pair.sample_even    = sample_even_i;
  assign in_pair.sample_odd     = sample_odd_i;
  assign in_pair.first_of_block = first_of_block_i;
  assign in_pair.last_pair      = last_pair_i;

  iaenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pair_i  (in_pair),
    .q_valid_o  (q_valid),
    .q_pair_o   (q_pair),
    .q_pop_i    (q_pop)
  );

  iaenc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pair_i       (q_pair),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_block_o (end_of_block_o)
  );

endmodule

`default_nettype wire
